// ----- src/ghsp_pkg.sv -----
`timescale 1ns / 1ps

package ghsp_pkg;

   localparam int SLOT_COUNT   = 4096;
   localparam int GEN_BITS     = 12;
   localparam int IDX_W        = $clog2(SLOT_COUNT);
   localparam int TOP_W        = $clog2(SLOT_COUNT + 1);
   localparam int LIVE_W       = 13;
   localparam int HANDLE_IDX_W = 20;
   localparam int HANDLE_GEN_W = 12;

   localparam logic [1:0] OP_ALLOC    = 2'd0;
   localparam logic [1:0] OP_FREE     = 2'd1;
   localparam logic [1:0] OP_VALIDATE = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] handle_in;
      logic [3:0]  item_type;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       handle_out;
      logic [3:0]        type_out;
      logic [LIVE_W-1:0] live_slots;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctl_status_type;

endpackage

// ----- src/ghsp_controller.sv -----
`timescale 1ns / 1ps

module ghsp_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ghsp_pkg::ctl_status_type status,
   output ghsp_pkg::ctl_cmd_type    cmd,
   output logic                    busy
);
   import ghsp_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.clear  = (state_ff == S_CLEAR);
   assign cmd.accept = (state_ff == S_IDLE) && start;
   assign cmd.exec   = (state_ff == S_EXEC);
   assign busy       = (state_ff != S_IDLE);

endmodule

// ----- src/ghsp_datapath.sv -----
`timescale 1ns / 1ps

module ghsp_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  ghsp_pkg::ctl_cmd_type    cmd,
   input  ghsp_pkg::req_type        req_data,
   output ghsp_pkg::ctl_status_type status,
   output logic                     rsp_valid,
   output ghsp_pkg::rsp_type        rsp_data
);
   import ghsp_pkg::*;

   typedef struct packed {
      logic                slot_used;
      logic [GEN_BITS-1:0] slot_gen;
      logic [3:0]          slot_ty;
   } slot_entry_type;

   slot_entry_type slot_mem [SLOT_COUNT];
   logic [TOP_W-1:0] link_mem [SLOT_COUNT];

   slot_entry_type    slot_rd_ff;
   logic [TOP_W-1:0]  link_rd_ff;
   req_type           req_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              range_ff;
   logic              full_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [TOP_W-1:0]  free_top_ff;
   logic [TOP_W-1:0]  free_top_in;
   logic [LIVE_W-1:0] live_ff;
   logic [LIVE_W-1:0] live_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [HANDLE_IDX_W-1:0] field;
   logic                    range_ok;
   logic                    full;
   logic [IDX_W-1:0]        rd_addr;

   logic                slot_we;
   logic [IDX_W-1:0]    slot_waddr;
   slot_entry_type      slot_wdata;
   logic                link_we;
   logic [IDX_W-1:0]    link_waddr;
   logic [TOP_W-1:0]    link_wdata;
   logic                handle_ok;
   logic [GEN_BITS-1:0] gen_next;

   assign field    = req_data.handle_in[HANDLE_IDX_W-1:0];
   assign range_ok = (field != '0) && (field <= HANDLE_IDX_W'(SLOT_COUNT));
   assign full     = (free_top_ff == TOP_W'(SLOT_COUNT));

   always_comb begin
      if (req_data.opcode == OP_ALLOC) begin
         rd_addr = full ? '0 : free_top_ff[IDX_W-1:0];
      end else begin
         rd_addr = range_ok ? IDX_W'(field - HANDLE_IDX_W'(1)) : '0;
      end
   end

   assign gen_next  = slot_rd_ff.slot_gen + GEN_BITS'(1);
   assign handle_ok = range_ff && slot_rd_ff.slot_used &&
                      (HANDLE_GEN_W'(slot_rd_ff.slot_gen) ==
                       req_ff.handle_in[31:HANDLE_IDX_W]);

   always_comb begin
      slot_we     = 1'b0;
      slot_waddr  = idx_ff;
      slot_wdata  = slot_rd_ff;
      link_we     = 1'b0;
      link_waddr  = idx_ff;
      link_wdata  = free_top_ff;
      free_top_in = free_top_ff;
      live_in     = live_ff;
      rsp_in      = '{status: ST_BAD, handle_out: '0, type_out: '0, live_slots: live_ff};

      if (cmd.clear) begin
         slot_we    = 1'b1;
         slot_waddr = clr_ff;
         slot_wdata = '0;
         link_we    = 1'b1;
         link_waddr = clr_ff;
         link_wdata = TOP_W'(clr_ff) + TOP_W'(1);
      end else if (cmd.exec) begin
         case (req_ff.opcode)
            OP_ALLOC: begin
               if (full_ff) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  slot_we     = 1'b1;
                  slot_wdata  = '{slot_used: 1'b1, slot_gen: gen_next,
                                  slot_ty: req_ff.item_type};
                  free_top_in = link_rd_ff;
                  live_in     = live_ff + LIVE_W'(1);
                  rsp_in.status     = ST_OK;
                  rsp_in.handle_out = {HANDLE_GEN_W'(gen_next),
                                       HANDLE_IDX_W'(idx_ff) + HANDLE_IDX_W'(1)};
                  rsp_in.type_out   = req_ff.item_type;
               end
            end
            OP_FREE: begin
               if (handle_ok) begin
                  slot_we     = 1'b1;
                  slot_wdata  = '{slot_used: 1'b0, slot_gen: gen_next,
                                  slot_ty: slot_rd_ff.slot_ty};
                  link_we     = 1'b1;
                  free_top_in = TOP_W'(idx_ff);
                  live_in     = live_ff - LIVE_W'(1);
                  rsp_in.status     = ST_OK;
                  rsp_in.handle_out = req_ff.handle_in;
               end
            end
            OP_VALIDATE: begin
               if (handle_ok) begin
                  rsp_in.status     = ST_OK;
                  rsp_in.handle_out = req_ff.handle_in;
                  rsp_in.type_out   = slot_rd_ff.slot_ty;
               end
            end
            default: begin
               rsp_in.status = ST_BAD;
            end
         endcase
         rsp_in.live_slots = live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (cmd.accept) begin
         slot_rd_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (cmd.accept) begin
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff   <= req_data;
         idx_ff   <= rd_addr;
         range_ff <= range_ok;
         full_ff  <= full;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         free_top_ff  <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
         free_top_ff  <= free_top_in;
         live_ff      <= live_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   assign status.clear_last = (clr_ff == IDX_W'(SLOT_COUNT - 1));
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;

endmodule

// ----- src/generational_handle_slot_pool.sv -----
`timescale 1ns / 1ps
// A request is taken only while idle; the slot and free-link memories are read
// in the cycle of acceptance and updated in the following one, and the response
// strobe is registered from that update, and no new request is taken meanwhile.
// After reset a clearing pass writes one slot per cycle over all 4096 slots, with
// busy high. The receiver cannot stall, and each response is shown for one cycle.

module generational_handle_slot_pool (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ghsp_pkg::req_type req_data,
   output logic              rsp_valid,
   output ghsp_pkg::rsp_type rsp_data
);
   import ghsp_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   ghsp_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ghsp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("response missing two cycles after acceptance");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses on consecutive cycles");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
         (rsp_data.live_slots == LIVE_W'(SLOT_COUNT)))
      else $error("pool reported full with free slots left");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ghsp_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         RETIRED_KEEP = 64;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   generational_handle_slot_pool dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Shadow copy of the pool.
   bit                slot_live [SLOT_COUNT];
   logic [GEN_BITS-1:0] slot_gen [SLOT_COUNT];
   logic [TOP_W-1:0]  next_free [SLOT_COUNT];
   logic [3:0]        slot_kind [SLOT_COUNT];
   logic [TOP_W-1:0]  free_head;
   logic [LIVE_W-1:0] live_count;

   // Bookkeeping used to build well-formed requests.
   int          live_slots_list[$];
   int          slot_pos [SLOT_COUNT];
   logic [31:0] retired_handles[$];
   logic [31:0] last_alloc_handle;

   req_type req_backlog[$];
   rsp_type predicted_rsp[$];
   int      issued_cnt   = 0;
   int      accepted_cnt = 0;
   int      err_count    = 0;
   int      op_seen [4]  = '{default: 0};
   int      status_seen [4] = '{default: 0};
   int      peak_live    = 0;
   int      rsp_cnt      = 0;
   int      gap_left     = 0;
   int      burst_left   = 1;
   int      idle_cycles  = 0;

   task automatic log_error(input string msg);
      $display("ERROR: %s", msg);
      err_count++;
   endtask

   function automatic void pool_reset();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_live[i] = 1'b0;
         slot_gen[i]  = '0;
         next_free[i] = TOP_W'(i + 1);
         slot_kind[i] = '0;
      end
      free_head  = '0;
      live_count = '0;
      live_slots_list.delete();
      retired_handles.delete();
   endfunction

   function automatic logic [31:0] make_handle(input int s);
      logic [31:0] h;
      h        = '0;
      h[31:20] = slot_gen[s];
      h[19:0]  = 20'(s + 1);
      return h;
   endfunction

   function automatic logic [31:0] pick_live();
      return make_handle(live_slots_list[$urandom_range(0, live_slots_list.size() - 1)]);
   endfunction

   function automatic rsp_type slot_pool_step(input req_type r);
      rsp_type     res;
      logic [19:0] ix;
      bit          good;
      int          s;
      int          p;
      int          tail;
      res        = '0;
      res.status = ST_BAD;
      ix         = r.handle_in[19:0] - 20'd1;
      s          = int'(ix);
      good       = (r.handle_in != 32'd0) && (ix < SLOT_COUNT);
      if (good) good = slot_live[s] && (slot_gen[s] == r.handle_in[31:20]);
      case (r.opcode)
         OP_ALLOC: begin
            if (free_head >= SLOT_COUNT) begin
               res.status = ST_FULL;
            end else begin
               s            = int'(free_head);
               free_head    = next_free[s];
               slot_live[s] = 1'b1;
               slot_gen[s]  = slot_gen[s] + 1'b1;
               slot_kind[s] = r.item_type;
               live_count   = live_count + 1'b1;
               res.status     = ST_OK;
               res.handle_out = make_handle(s);
               res.type_out   = r.item_type;
               last_alloc_handle = res.handle_out;
               slot_pos[s] = live_slots_list.size();
               live_slots_list.insert(live_slots_list.size(), s);
            end
         end
         OP_FREE: begin
            if (good) begin
               slot_live[s] = 1'b0;
               slot_gen[s]  = slot_gen[s] + 1'b1;
               next_free[s] = free_head;
               free_head    = TOP_W'(s);
               live_count   = live_count - 1'b1;
               res.status     = ST_OK;
               res.handle_out = r.handle_in;
               retired_handles.insert(retired_handles.size(), r.handle_in);
               if (retired_handles.size() > RETIRED_KEEP) void'(retired_handles.pop_front());
               p    = slot_pos[s];
               tail = live_slots_list[$];
               live_slots_list[p] = tail;
               slot_pos[tail]     = p;
               live_slots_list.delete(live_slots_list.size() - 1);
            end
         end
         OP_VALIDATE: begin
            if (good) begin
               res.status     = ST_OK;
               res.handle_out = r.handle_in;
               res.type_out   = slot_kind[s];
            end
         end
         default: begin
         end
      endcase
      res.live_slots = live_count;
      return res;
   endfunction

   // Driver: takes requests from the backlog in bursts, mostly separated by idle gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted_rsp.insert(predicted_rsp.size(), slot_pool_step(req_data));
            op_seen[req_data.opcode]++;
            accepted_cnt++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start    <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data <= req_backlog.pop_front();
               start    <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         rsp_cnt++;
         if (predicted_rsp.size() == 0) begin
            log_error($sformatf("response %0d arrived with nothing outstanding", rsp_cnt));
         end else begin
            want = predicted_rsp.pop_front();
            status_seen[want.status]++;
            if (int'(want.live_slots) > peak_live) peak_live = int'(want.live_slots);
            if (rsp_data.status !== want.status)
               log_error($sformatf("response %0d status: got %0d, expected %0d",
                                   rsp_cnt, rsp_data.status, want.status));
            if (rsp_data.handle_out !== want.handle_out)
               log_error($sformatf("response %0d handle_out: got %h, expected %h",
                                   rsp_cnt, rsp_data.handle_out, want.handle_out));
            if (rsp_data.type_out !== want.type_out)
               log_error($sformatf("response %0d type_out: got %h, expected %h",
                                   rsp_cnt, rsp_data.type_out, want.type_out));
            if (rsp_data.live_slots !== want.live_slots)
               log_error($sformatf("response %0d live_slots: got %0d, expected %0d",
                                   rsp_cnt, rsp_data.live_slots, want.live_slots));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT: no request or response for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Each request is issued only after the previous one was accepted, so the
   // shadow state is current when the next request is built from it.
   task automatic send(input logic [1:0] op, input logic [31:0] h, input logic [3:0] ty);
      req_type r;
      r.opcode    = op;
      r.handle_in = h;
      r.item_type = ty;
      req_backlog.insert(req_backlog.size(), r);
      issued_cnt++;
      while (accepted_cnt != issued_cnt) @(negedge clock);
   endtask

   task automatic drain();
      while (predicted_rsp.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [31:0] h_a;
      logic [31:0] h_b;
      logic [31:0] h_c;
      logic [31:0] h;
      logic [31:0] noise;
      logic [3:0]  ty;
      logic [1:0]  op_fv;
      int          pick;
      int          waited;

      pool_reset();

      send(OP_VALIDATE, 32'd0, 4'h0);
      send(OP_FREE, 32'd0, 4'hF);
      send(OP_ALLOC, 32'hFFFF_FFFF, 4'hF);
      h_a = last_alloc_handle;
      send(OP_ALLOC, 32'd0, 4'h0);
      h_b = last_alloc_handle;
      send(OP_VALIDATE, h_a, 4'h0);
      send(OP_VALIDATE, h_b, 4'hF);
      send(OP_VALIDATE, {h_a[31:20], 20'd0}, 4'h0);
      send(OP_VALIDATE, 32'hFFFF_FFFF, 4'h0);
      send(OP_VALIDATE, {h_a[31:20], 20'(SLOT_COUNT + 1)}, 4'h0);
      send(OP_VALIDATE, {12'h001, 20'(SLOT_COUNT)}, 4'h0);
      send(OP_VALIDATE, {h_a[31:20] + 12'd1, h_a[19:0]}, 4'h0);
      send(OP_UNUSED, h_a, 4'hF);
      send(OP_UNUSED, 32'hFFFF_FFFF, 4'h0);
      send(OP_FREE, {h_b[31:20] ^ 12'h800, h_b[19:0]}, 4'h0);
      send(OP_FREE, h_a, 4'hF);
      send(OP_FREE, h_a, 4'h0);
      send(OP_VALIDATE, h_a, 4'h0);
      send(OP_ALLOC, 32'd0, 4'h5);
      h_c = last_alloc_handle;
      send(OP_VALIDATE, h_c, 4'h0);
      send(OP_FREE, h_b, 4'h0);
      send(OP_FREE, h_c, 4'h0);
      drain();

      for (int n = 0; n < 1300; n++) begin
         pick  = $urandom_range(0, 99);
         ty    = 4'($urandom_range(0, 15));
         noise = $urandom;
         op_fv = ($urandom_range(0, 1) != 0) ? OP_FREE : OP_VALIDATE;
         if (live_slots_list.size() == 0 &&
             ((pick >= 35 && pick < 85) || (pick >= 96 && pick < 98)))
            pick = 0;
         if (live_slots_list.size() > 300 && pick < 35) pick = 40;
         if (pick < 35) begin
            send(OP_ALLOC, noise, ty);
         end else if (pick < 60) begin
            send(OP_FREE, pick_live(), ty);
         end else if (pick < 85) begin
            send(OP_VALIDATE, pick_live(), ty);
         end else if (pick < 90) begin
            h = (retired_handles.size() > 0) ?
                retired_handles[$urandom_range(0, retired_handles.size() - 1)] : noise;
            send(op_fv, h, ty);
         end else if (pick < 94) begin
            send(op_fv, noise, ty);
         end else if (pick < 96) begin
            send(OP_UNUSED, noise, ty);
         end else if (pick < 98) begin
            h = pick_live();
            h[31:20] = h[31:20] ^ 12'($urandom_range(1, 4095));
            send(op_fv, h, ty);
         end else begin
            h = noise;
            h[19:0] = ($urandom_range(0, 1) != 0) ? 20'd0 :
                      20'($urandom_range(SLOT_COUNT + 1, 20'hFFFFF));
            send(op_fv, h, ty);
         end
         if ($urandom_range(0, 149) == 0) drain();
      end

      waited = 0;
      while (predicted_rsp.size() != 0 && waited < 200) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (predicted_rsp.size() != 0)
         log_error($sformatf("%0d responses never arrived", predicted_rsp.size()));

      $display("Requests: %0d allocate, %0d free, %0d validate, %0d unused opcode.",
               op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_VALIDATE], op_seen[OP_UNUSED]);
      $display("Responses: %0d ok, %0d pool full, %0d rejected; peak occupancy %0d slots.",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD], peak_live);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
